// ===== rtl/wall_texel_shader_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef WALL_TEXEL_SHADER_UNIT_MACROS_SVH
`define WALL_TEXEL_SHADER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define WTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define WTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

    // Texture geometry defaults
    localparam int TEX_W_DEF   = 64;
    localparam int TEX_H_DEF   = 64;
    localparam int NUM_TEX_DEF = 5;

    // Stream widths
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] MAP_WIDTH_RST  = 8'd24;
    localparam logic [CFG_DATA_W-1:0] MAP_HEIGHT_RST = 8'd24;

    // Request kinds (tuser)
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SHADE = 1'b1;

    // Wall directions
    localparam logic [2:0] DIR_EAST  = 3'd0;
    localparam logic [2:0] DIR_NORTH = 3'd1;
    localparam logic [2:0] DIR_WEST  = 3'd2;
    localparam logic [2:0] DIR_SOUTH = 3'd3;
    localparam logic [2:0] DIR_EXTRA = 3'd4;

    // Luminosity: Q1.8 value up to 256, numerator 256*(w+h) fits 17 bits
    localparam int LUM_W  = 9;
    localparam int LSUM_W = 9;
    localparam int LN_W   = 17;

endpackage

`default_nettype wire

// ===== rtl/wall_texel_shader_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel        | Direction | Handshake                      | Payload
// ---------------+-----------+--------------------------------+-------------------------------
// s_axis         | in        | i_s_axis_tvalid/o_s_axis_tready | tuser req kind, tdata fields
// m_axis         | out       | o_m_axis_tvalid/i_m_axis_tready | tdata color, column, row
// cfg            | in        | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One word enters per cycle while the output is not stalled; each word passes through
// the pipeline, whose two restoring dividers resolve one quotient bit per stage.
// Texel writes retire in the memory stage in stream order with the shade reads,
// so a shade word always sees every earlier write. Writes produce no output word.
// Reset (synchronous, active low) clears all stage valid bits and loads the map registers
// with their reset values; texture memory contents are undefined until written.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.

module wall_texel_shader_unit #(
    parameter int TEX_W   = wts_pkg::TEX_W_DEF,
    parameter int TEX_H   = wts_pkg::TEX_H_DEF,
    parameter int NUM_TEX = wts_pkg::NUM_TEX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata, low bit up: wall_dir[3], texel_addr[12], texel_value[24], hit_frac_x[10],
    // hit_frac_y[10], distance[16], screen_column[12], row[12], wall_top[13],
    // wall_height[13], zero pad[3]
    input  wire logic [wts_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: req_type[1]
    input  wire logic [wts_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata, low bit up: pixel_color[24], out_column[12], out_row[12]
    output logic [wts_pkg::M_TDATA_W-1:0]        o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [wts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wts_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wts_pkg::*;

    localparam int TEX_SIZE  = TEX_W * TEX_H;
    localparam int MEM_DEPTH = NUM_TEX * TEX_SIZE;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int TX_W      = $clog2(TEX_W);
    localparam int TY_W      = $clog2(TEX_H);
    localparam int TEXH_W    = $clog2(TEX_H + 1);
    localparam int RR_W      = 13 + TEXH_W;          // offset * TEX_H
    localparam int ND        = (TY_W > LUM_W) ? TY_W : LUM_W;

    typedef struct packed {
        logic               valid;
        logic               shade;
        logic [2:0]         dir;
        logic [11:0]        waddr;
        logic [23:0]        value;
        logic [9:0]         fx;
        logic [9:0]         fy;
        logic [15:0]        ray_dist;
        logic [11:0]        col;
        logic [11:0]        row;
        logic signed [12:0] top;
        logic [12:0]        height;
    } t_s0;

    typedef struct packed {
        logic               valid;
        logic               shade;
        logic               dirok;
        logic               wrok;
        logic [MEM_AW-1:0]  base;
        logic [11:0]        waddr;
        logic [23:0]        value;
        logic [TX_W-1:0]    tx;
        logic [11:0]        col;
        logic [11:0]        row;
        logic               neg;
        logic [12:0]        mag;
        logic [12:0]        height;
        logic               lz;
        logic [LN_W-1:0]    lnum;
        logic [LSUM_W-1:0]  lden;
    } t_s1;

    typedef struct packed {
        logic               valid;
        logic               shade;
        logic               dirok;
        logic               wrok;
        logic [MEM_AW-1:0]  base;
        logic [11:0]        waddr;
        logic [23:0]        value;
        logic [TX_W-1:0]    tx;
        logic [11:0]        col;
        logic [11:0]        row;
        logic               neg;
        logic               rsat;
        logic [RR_W-1:0]    rrem;
        logic [12:0]        rdiv;
        logic [ND-1:0]      rq;
        logic               lz;
        logic [LN_W-1:0]    lrem;
        logic [LSUM_W-1:0]  lden;
        logic [ND-1:0]      lq;
    } t_dv;

    typedef struct packed {
        logic               valid;
        logic               shade;
        logic               wrok;
        logic [MEM_AW-1:0]  addr;
        logic [23:0]        value;
        logic [LUM_W-1:0]   lum;
        logic [11:0]        col;
        logic [11:0]        row;
    } t_s3;

    typedef struct packed {
        logic               valid;
        logic               shade;
        logic [LUM_W-1:0]   lum;
        logic [11:0]        col;
        logic [11:0]        row;
    } t_s4;

    // Pipeline advances as a whole whenever the output slot is free or being taken.
    logic w_en;

    logic [CFG_DATA_W-1:0] r_map_w;
    logic [CFG_DATA_W-1:0] r_map_h;

    t_s0 r_s0, n_s0;
    t_s1 r_s1, n_s1;
    t_dv r_dv [ND+1];
    t_dv n_dv [ND+1];
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;

    logic [23:0] r_mem [MEM_DEPTH];
    logic [23:0] r_tex;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] n_out_data;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // Map sizes; the user must write them only while the pipeline is drained (unenforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= MAP_WIDTH_RST;
            r_map_h <= MAP_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: unpack the input word.
    always_comb begin
        n_s0.valid    = i_s_axis_tvalid;
        n_s0.shade    = (i_s_axis_tuser[0] == REQ_SHADE);
        n_s0.dir      = i_s_axis_tdata[2:0];
        n_s0.waddr    = i_s_axis_tdata[14:3];
        n_s0.value    = i_s_axis_tdata[38:15];
        n_s0.fx       = i_s_axis_tdata[48:39];
        n_s0.fy       = i_s_axis_tdata[58:49];
        n_s0.ray_dist = i_s_axis_tdata[74:59];
        n_s0.col      = i_s_axis_tdata[86:75];
        n_s0.row      = i_s_axis_tdata[98:87];
        n_s0.top      = i_s_axis_tdata[111:99];
        n_s0.height   = i_s_axis_tdata[124:112];
    end

    // Stage 1: texture column, slice offset, texture base, fade numerator.
    always_comb begin
        logic [9:0]         frac;
        logic signed [13:0] offs;
        logic [LSUM_W-1:0]  sum;
        logic [LN_W-1:0]    full;
        logic [LN_W-1:0]    twice;

        // East and west walls run along y.
        frac  = (r_s0.dir == DIR_EAST || r_s0.dir == DIR_WEST) ? r_s0.fy : r_s0.fx;
        offs  = $signed({2'b00, r_s0.row}) - $signed({r_s0.top[12], r_s0.top});
        sum   = LSUM_W'(r_map_w) + LSUM_W'(r_map_h);
        full  = LN_W'({sum, 8'h00});
        twice = LN_W'({r_s0.ray_dist, 1'b0});

        n_s1.valid  = r_s0.valid;
        n_s1.shade  = r_s0.shade;
        n_s1.dirok  = (32'(r_s0.dir) < 32'(NUM_TEX));
        n_s1.wrok   = n_s1.dirok && (32'(r_s0.waddr) < 32'(TEX_SIZE));
        n_s1.base   = n_s1.dirok ? MEM_AW'(32'(r_s0.dir) * TEX_SIZE) : '0;
        n_s1.waddr  = r_s0.waddr;
        n_s1.value  = r_s0.value;
        n_s1.tx     = TX_W'((32'(frac) * TEX_W) >> 10);
        n_s1.col    = r_s0.col;
        n_s1.row    = r_s0.row;
        n_s1.neg    = offs[13];
        n_s1.mag    = offs[12:0];
        n_s1.height = r_s0.height;
        n_s1.lz     = (sum == '0) || (twice >= full);
        n_s1.lnum   = full - twice;
        n_s1.lden   = sum;
    end

    // Divider entry: scaled row numerator and saturation check.
    always_comb begin
        logic [RR_W-1:0] rnum;
        logic [RR_W-1:0] cap;

        rnum = RR_W'(32'(r_s1.mag) * TEX_H);
        cap  = RR_W'(32'(r_s1.height) * TEX_H);

        n_dv[0].valid = r_s1.valid;
        n_dv[0].shade = r_s1.shade;
        n_dv[0].dirok = r_s1.dirok;
        n_dv[0].wrok  = r_s1.wrok;
        n_dv[0].base  = r_s1.base;
        n_dv[0].waddr = r_s1.waddr;
        n_dv[0].value = r_s1.value;
        n_dv[0].tx    = r_s1.tx;
        n_dv[0].col   = r_s1.col;
        n_dv[0].row   = r_s1.row;
        n_dv[0].neg   = r_s1.neg;
        // Quotient at or past TEX_H, including a zero height, saturates.
        n_dv[0].rsat  = !r_s1.neg && (rnum >= cap);
        n_dv[0].rrem  = r_s1.neg ? '0 : rnum;
        n_dv[0].rdiv  = r_s1.height;
        n_dv[0].rq    = '0;
        n_dv[0].lz    = r_s1.lz;
        n_dv[0].lrem  = r_s1.lnum;
        n_dv[0].lden  = r_s1.lden;
        n_dv[0].lq    = '0;
    end

    // Divider stages: one quotient bit of each division per stage, MSB first.
    for (genvar k = 0; k < ND; k++) begin : g_div
        localparam int SH = ND - 1 - k;

        always_comb begin
            logic [RR_W+ND-1:0] rs;
            logic [RR_W+ND-1:0] rd;
            logic [LN_W+ND-1:0] ls;
            logic [LN_W+ND-1:0] ld;

            rs = (RR_W+ND)'(r_dv[k].rrem);
            rd = (RR_W+ND)'(r_dv[k].rdiv) << SH;
            ls = (LN_W+ND)'(r_dv[k].lrem);
            ld = (LN_W+ND)'(r_dv[k].lden) << SH;

            n_dv[k+1] = r_dv[k];
            if (rs >= rd) begin
                n_dv[k+1].rrem   = RR_W'(rs - rd);
                n_dv[k+1].rq[SH] = 1'b1;
            end
            if (ls >= ld) begin
                n_dv[k+1].lrem   = LN_W'(ls - ld);
                n_dv[k+1].lq[SH] = 1'b1;
            end
        end
    end

    // Address stage: texture row, final luminosity, memory address.
    always_comb begin
        logic [TY_W-1:0]   ty;
        logic [MEM_AW-1:0] taddr;

        if (r_dv[ND].neg) begin
            ty = '0;
        end else if (r_dv[ND].rsat) begin
            ty = TY_W'(TEX_H - 1);
        end else begin
            ty = TY_W'(r_dv[ND].rq);
        end
        taddr = MEM_AW'(32'(ty) * TEX_W) + MEM_AW'(r_dv[ND].tx);

        n_s3.valid = r_dv[ND].valid;
        n_s3.shade = r_dv[ND].shade;
        n_s3.wrok  = r_dv[ND].wrok;
        n_s3.addr  = r_dv[ND].base + (r_dv[ND].shade ? taddr : MEM_AW'(r_dv[ND].waddr));
        n_s3.value = r_dv[ND].value;
        // Black for a bad texture select, a zero fade sum, or at or past the fade distance.
        n_s3.lum   = (r_dv[ND].lz || !r_dv[ND].dirok) ? '0 : LUM_W'(r_dv[ND].lq);
        n_s3.col   = r_dv[ND].col;
        n_s3.row   = r_dv[ND].row;
    end

    // Memory stage: write or read in stream order.
    always_comb begin
        n_s4.valid = r_s3.valid;
        n_s4.shade = r_s3.shade;
        n_s4.lum   = r_s3.lum;
        n_s4.col   = r_s3.col;
        n_s4.row   = r_s3.row;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_s3.valid && !r_s3.shade && r_s3.wrok) begin
                r_mem[r_s3.addr] <= r_s3.value;
            end
            r_tex <= r_mem[r_s3.addr];
        end
    end

    // Fade stage: scale each channel by luminosity, truncate.
    always_comb begin
        logic [CFG_DATA_W+LUM_W-1:0] pr;
        logic [CFG_DATA_W+LUM_W-1:0] pg;
        logic [CFG_DATA_W+LUM_W-1:0] pb;

        pr = (CFG_DATA_W+LUM_W)'(r_tex[23:16]) * (CFG_DATA_W+LUM_W)'(r_s4.lum);
        pg = (CFG_DATA_W+LUM_W)'(r_tex[15:8])  * (CFG_DATA_W+LUM_W)'(r_s4.lum);
        pb = (CFG_DATA_W+LUM_W)'(r_tex[7:0])   * (CFG_DATA_W+LUM_W)'(r_s4.lum);

        // Zero luminosity gives black whatever texel was fetched.
        n_out_data = {r_s4.row, r_s4.col,
                      (r_s4.lum == '0) ? 24'h000000 : {pr[15:8], pg[15:8], pb[15:8]}};
    end

    // Stage registers; valid bits reset, payload does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
            r_s1.valid <= 1'b0;
            for (int k = 0; k <= ND; k++) begin
                r_dv[k].valid <= 1'b0;
            end
            r_s3.valid  <= 1'b0;
            r_s4.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            for (int k = 0; k <= ND; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            // Drop texel writes here; only shade words leave.
            r_out_valid <= r_s4.valid && r_s4.shade;
            r_out_data  <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "wall_texel_shader_unit_macros.svh"

module wts_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [wts_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire logic [wts_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    input  wire logic                            i_s_axis_tvalid,
    input  wire logic                            o_s_axis_tready,
    input  wire logic [wts_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  wire logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            o_cfg_ready,
    input  wire logic [wts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wts_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wts_pkg::*;

    // Hold a stalled output word.
    `WTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output word changed under stall")

    // An empty output slot never blocks the input.
    `WTS_ASSERT_IMP(a_in_free, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input blocked with empty output")

    // Reset empties the pipeline.
    `WTS_ASSERT_NXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_m_axis_tvalid, "output valid right after reset")

    // Configuration writes are always taken.
    `WTS_ASSERT_IMP(a_cfg_take, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "configuration write refused")

endmodule

bind wall_texel_shader_unit wts_checker u_wts_checker (.*);

`default_nettype wire

// ===== dv/wall_texel_shader_unit_tb.sv =====
`timescale 1ns / 1ps

// Stream test of the wall texel shader.
// Texel writes fill a local copy of the five texture memories; every shade word
// accepted on the input side is predicted here, in stream order with the writes,
// and queued as an expected pixel. The output monitor pops the oldest pixel for
// each word it takes and compares color, column and row one by one.
// A shade word is only sent once the texel that it addresses has been written,
// so the undefined memory contents are never read.
// Map registers change only between phases, with the pipeline drained.
module wall_texel_shader_unit_tb;

    import wts_pkg::*;

    localparam int TEX_W    = TEX_W_DEF;
    localparam int TEX_H    = TEX_H_DEF;
    localparam int NUM_TEX  = NUM_TEX_DEF;
    localparam int TEX_SIZE = TEX_W * TEX_H;
    // drain wait after the last word, with slack past the pipeline depth
    localparam int TAIL_CYCLES = 30;

    typedef struct packed {
        logic        req;
        logic [2:0]  dir;
        logic [11:0] addr;
        logic [23:0] texel;
        logic [9:0]  frac_x;
        logic [9:0]  frac_y;
        logic [15:0] ray_dist;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] top;
        logic [12:0] height;
    } t_texel_word;

    typedef struct packed {
        logic [23:0] color;
        logic [11:0] column;
        logic [11:0] row;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAP_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // words waiting to be sent, and pixels waiting to come out
    t_texel_word word_q[$];
    t_pixel      pixel_q[$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          mismatch_count = 0;

    // idle chance in percent on each side, set per phase
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    t_texel_word cur_word;

    // predictor state: texture copy and map registers
    logic [23:0]     tex_copy [0:NUM_TEX*TEX_SIZE-1];
    bit              tex_planned [0:NUM_TEX*TEX_SIZE-1];
    logic [7:0]      fade_w = MAP_WIDTH_RST;
    logic [7:0]      fade_h = MAP_HEIGHT_RST;

    wall_texel_shader_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Texel that a shade word reads, or -1 for a bad texture select.
    function automatic int texel_index(input t_texel_word w);
        int unsigned frac;
        int unsigned tx;
        int unsigned ty;
        int          offs;
        if (w.dir >= NUM_TEX) return -1;
        // west and east walls run along y
        frac = (w.dir == DIR_EAST || w.dir == DIR_WEST) ? w.frac_y : w.frac_x;
        tx   = (frac * TEX_W) >> 10;
        offs = int'(w.row) - int'($signed(w.top));
        if (offs < 0) begin
            // row above the slice
            ty = 0;
        end else if (w.height == 0) begin
            ty = TEX_H - 1;
        end else begin
            ty = (offs * TEX_H) / int'(w.height);
            // row below the slice saturates
            if (ty > TEX_H - 1) ty = TEX_H - 1;
        end
        return int'(w.dir) * TEX_SIZE + ty * TEX_W + tx;
    endfunction

    // Store a texel, or predict the pixel of a shade word.
    function automatic void apply_texel_word(input t_texel_word w);
        int unsigned sum;
        int unsigned full;
        int unsigned twice;
        int unsigned lum;
        int          idx;
        logic [23:0] texel;
        t_pixel      px;
        if (w.req == REQ_WRITE) begin
            // a bad texture select drops the write; every 12-bit address is in range
            if (w.dir < NUM_TEX) tex_copy[int'(w.dir) * TEX_SIZE + w.addr] = w.texel;
            return;
        end
        px.color  = '0;
        px.column = w.column;
        px.row    = w.row;
        idx = texel_index(w);
        if (idx >= 0) begin
            texel = tex_copy[idx];
            sum   = fade_w + fade_h;
            full  = 256 * sum;
            twice = 2 * w.ray_dist;
            // at or beyond the fade distance, or with a zero map size, the wall is black
            lum = (sum == 0 || twice >= full) ? 0 : (full - twice) / sum;
            px.color[23:16] = 8'((int'(texel[23:16]) * lum) >> 8);
            px.color[15:8]  = 8'((int'(texel[15:8]) * lum) >> 8);
            px.color[7:0]   = 8'((int'(texel[7:0]) * lum) >> 8);
        end
        pixel_q.push_back(px);
    endfunction

    task automatic flag_pixel_error(input string field, input logic [23:0] got,
                                    input logic [23:0] want);
        if (mismatch_count < 200)
            $display("%0t: %s got %h, want %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // All fields random; callers override what matters.
    function automatic t_texel_word random_word();
        logic [127:0] raw;
        t_texel_word  w;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w   = raw[$bits(t_texel_word)-1:0];
        return w;
    endfunction

    task automatic queue_write(input logic [2:0] dir, input logic [11:0] addr,
                               input logic [23:0] value);
        t_texel_word w;
        w       = random_word();
        w.req   = REQ_WRITE;
        w.dir   = dir;
        w.addr  = addr;
        w.texel = value;
        if (dir < NUM_TEX) tex_planned[int'(dir) * TEX_SIZE + addr] = 1'b1;
        word_q.push_back(w);
        words_queued++;
    endtask

    // Send a shade word, writing its texel first if nothing has been stored there.
    task automatic queue_shade(input t_texel_word w);
        int idx;
        idx = texel_index(w);
        if (idx >= 0 && !tex_planned[idx])
            queue_write(w.dir, 12'(idx % TEX_SIZE), 24'($urandom));
        word_q.push_back(w);
        words_queued++;
    endtask

    function automatic t_texel_word shade_word(input logic [2:0] dir, input int fx,
                                               input int fy, input int rdist,
                                               input int column, input int row,
                                               input int top, input int height);
        t_texel_word w;
        w          = random_word();
        w.req      = REQ_SHADE;
        w.dir      = dir;
        w.frac_x   = 10'(fx);
        w.frac_y   = 10'(fy);
        w.ray_dist = 16'(rdist);
        w.column   = 12'(column);
        w.row      = 12'(row);
        w.top      = 13'(top);
        w.height   = 13'(height);
        return w;
    endfunction

    task automatic queue_random_shade();
        t_texel_word w;
        int          top;
        int          height;
        w     = random_word();
        w.req = REQ_SHADE;
        // mostly real textures, now and then a bad select
        w.dir = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_TEX, 7))
                                            : 3'($urandom_range(0, NUM_TEX - 1));
        // spread distances over the fade range and beyond
        w.ray_dist = w.ray_dist >> $urandom_range(0, 10);
        case ($urandom_range(0, 3))
            0: begin
                // raw geometry: keep the random fields
            end
            1: begin
                // tiny slices, zero height included
                height   = $urandom_range(0, 2);
                top      = int'($urandom_range(0, 200)) - 100;
                w.height = 13'(height);
                w.top    = 13'(top);
                w.row    = 12'($urandom_range(0, 200));
            end
            default: begin
                // rows inside a believable slice
                height   = $urandom_range(1, 700);
                top      = int'($urandom_range(0, 900)) - 300;
                w.height = 13'(height);
                w.top    = 13'(top);
                w.row    = 12'(top + int'($urandom_range(0, height - 1)));
            end
        endcase
        queue_shade(w);
    endtask

    // Hold until every word is in and every pixel is out, then let the tail settle.
    task automatic wait_drained();
        while (words_taken != words_queued || pixel_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write both map registers back to back; valid stays up between them.
    task automatic set_fade(input logic [7:0] w, input logic [7:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAP_WIDTH;
        cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        fade_w = w;
        cfg_index <= CFG_MAP_HEIGHT;
        cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        fade_h = h;
        cfg_valid <= 1'b0;
    endtask

    // Input driver: predict on acceptance, then present the next word or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                apply_texel_word(cur_word);
                words_taken++;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
                    // idle burst; gap_left holds its extra idle slots
                    gap_left = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    s_tdata  <= {3'b000, cur_word.height, cur_word.top, cur_word.row,
                                 cur_word.column, cur_word.ray_dist, cur_word.frac_y,
                                 cur_word.frac_x, cur_word.texel, cur_word.addr,
                                 cur_word.dir};
                    s_tuser  <= cur_word.req;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each accepted pixel, then decide on back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    flag_pixel_error("unexpected pixel", o_m_axis_tdata[23:0], '0);
                end else begin
                    t_pixel want;
                    want = pixel_q.pop_front();
                    if (o_m_axis_tdata[23:0] !== want.color)
                        flag_pixel_error("pixel_color", o_m_axis_tdata[23:0], want.color);
                    if (o_m_axis_tdata[35:24] !== want.column)
                        flag_pixel_error("out_column", 24'(o_m_axis_tdata[35:24]),
                                         24'(want.column));
                    if (o_m_axis_tdata[47:36] !== want.row)
                        flag_pixel_error("out_row", 24'(o_m_axis_tdata[47:36]),
                                         24'(want.row));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int p;
        int stop_at;
        int pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset map size.
        gap_pct   = 25;
        stall_pct = 25;
        queue_write(DIR_EAST, 12'd0, 24'hFFFFFF);
        queue_write(DIR_NORTH, 12'd4095, 24'h000000);
        queue_write(DIR_WEST, 12'd63, 24'h808080);
        queue_write(DIR_SOUTH, 12'd4032, 24'h123456);
        queue_write(DIR_EXTRA, 12'd2080, 24'hEDCBA9);
        // bad texture selects: these writes must be dropped
        queue_write(3'd7, 12'd0, 24'h00FF00);
        queue_write(3'd5, 12'd4095, 24'h5A5A5A);
        // full brightness, top-left texel, still white after the dropped write
        queue_shade(shade_word(DIR_EAST, 1023, 0, 0, 0, 0, 0, 64));
        // row below the slice, rightmost column
        queue_shade(shade_word(DIR_NORTH, 1023, 0, 1, 4095, 4095, 0, 1));
        // row above the slice, farthest distance
        queue_shade(shade_word(DIR_WEST, 0, 1023, 65535, 1, 0, 4095, 8191));
        // zero wall height, lowest wall top
        queue_shade(shade_word(DIR_SOUTH, 0, 0, 100, 2, 17, -4096, 0));
        // just inside and exactly at the fade distance
        queue_shade(shade_word(DIR_EXTRA, 512, 0, 6143, 3, 50, 0, 100));
        queue_shade(shade_word(DIR_EXTRA, 512, 0, 6144, 4, 50, 0, 100));
        queue_shade(shade_word(DIR_EXTRA, 512, 0, 3000, 5, 50, 0, 100));
        // bad texture selects on shade words give black
        queue_shade(shade_word(3'd5, 100, 200, 10, 6, 7, 0, 64));
        queue_shade(shade_word(3'd6, 100, 200, 10, 7, 7, 0, 64));
        queue_shade(shade_word(3'd7, 100, 200, 10, 8, 7, 0, 64));
        // longest offset into the tallest slice
        queue_shade(shade_word(DIR_EAST, 0, 1023, 50, 9, 4095, -4096, 8191));
        wait_drained();

        // Zero map size: everything fades to black.
        set_fade(8'd0, 8'd0);
        queue_shade(shade_word(DIR_EAST, 1023, 0, 0, 10, 0, 0, 64));
        repeat (8) queue_random_shade();
        wait_drained();

        // Random phases over several map sizes; the last runs without idling.
        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_fade(8'd1, 8'd1);
                1: set_fade(8'd255, 8'd255);
                2: set_fade(8'd255, 8'd1);
                3: set_fade(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
                4: set_fade(8'd1, 8'd255);
                default: set_fade(8'd24, 8'd24);
            endcase
            gap_pct   = (p == 5) ? 0 : (p == 2) ? 0 : 30;
            stall_pct = (p == 5) ? 0 : (p == 3) ? 0 : 30;
            stop_at = words_queued + 105;
            while (words_queued < stop_at) begin
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    queue_write(3'($urandom_range(0, NUM_TEX - 1)), 12'($urandom),
                                24'($urandom));
                else if (pick == 3)
                    queue_write(3'($urandom_range(NUM_TEX, 7)), 12'($urandom),
                                24'($urandom));
                else
                    queue_random_shade();
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Give up well past the slowest legal run.
    initial begin
        #(2_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
